// ===== rtl/png_chunk_framer_crc32_unit_assert.svh =====
// Assertion macros for the PNG chunk framer, clocked on clk and held off while rst_n is low.
`ifndef PNG_CHUNK_FRAMER_CRC32_UNIT_ASSERT_SVH
`define PNG_CHUNK_FRAMER_CRC32_UNIT_ASSERT_SVH

`define PCF_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("framer assertion failed");

`define PCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("framer assertion failed");

`endif

// ===== rtl/pcf_pkg.sv =====
// Types, constants and CRC helpers shared by the PNG chunk framer modules.
package pcf_pkg;

  localparam logic        OP_START  = 1'b0;
  localparam logic        OP_DATA   = 1'b1;
  localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
  localparam int          STEP_W    = 4;

  localparam logic [STEP_W-1:0] STEP_LEN_LAST  = 4'd3;
  localparam logic [STEP_W-1:0] STEP_TYPE_0    = 4'd4;
  localparam logic [STEP_W-1:0] STEP_TYPE_LAST = 4'd7;
  localparam logic [STEP_W-1:0] STEP_HDR_END   = 4'd11;
  localparam logic [STEP_W-1:0] STEP_DATA_END  = 4'd4;

  typedef enum logic [1:0] {
    CMD_START,
    CMD_DATA,
    CMD_STRAY
  } cmd_kind_t;

  typedef struct packed {
    logic        op;
    logic [30:0] chunk_length;
    logic [31:0] chunk_type;
    logic [7:0]  data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_chunk;
    logic       error_flag;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic        err;
    logic        last;
    logic [30:0] length;
    logic [31:0] ctype;
    logic [7:0]  data;
  } cmd_t;

  typedef struct packed {
    logic chunk_open;
    logic bytes_zero;
  } fe_status_t;

  typedef struct packed {
    logic mid_cmd;
    logic head_valid;
  } be_status_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] be_byte(input logic [31:0] word, input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = word[31:24];
      2'd1:    r = word[23:16];
      2'd2:    r = word[15:8];
      default: r = word[7:0];
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/png_chunk_framer_crc32_unit.sv =====
// PNG chunk framer top level: one byte of the framed stream per result transaction.
//
// The input channel takes start items (length and type) and data items (one payload byte).
// The output channel delivers the framed byte stream: four big-endian length bytes, four
// type bytes, the payload bytes and four big-endian CRC-32 bytes, the last one flagged
// as the end of the chunk. A stray data byte yields one zero byte with the error flag set;
// a start while a chunk is open abandons that chunk and flags all its own results.
// An accepted item passes the command queue and then the output register, which raises
// out_valid. The byte sequencer emits one result per cycle while a command waits and
// out_stall is low: a start item its length and type bytes, a data item its payload byte,
// and the item closing a chunk also the four CRC bytes, so payload bytes flow at
// one per clock. A command queue of QUEUE_DEPTH entries sits between the front end and
// the sequencer; in_stall is high exactly while it is full. The output register holds its
// transaction while out_stall is high, and the sequencer waits behind it.
// Reset clears the queue, closes any chunk and returns the CRC to all ones.
`include "png_chunk_framer_crc32_unit_assert.svh"

module png_chunk_framer_crc32_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pcf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output pcf_pkg::out_item_t out_data
);

  logic                 accept, full, pop, head_valid;
  pcf_pkg::cmd_t        cmd, head;
  pcf_pkg::fe_status_t  fe_status;
  pcf_pkg::be_status_t  be_status;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  pcf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_data (in_data),
    .cmd     (cmd),
    .status  (fe_status)
  );

  pcf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_data  (cmd),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  pcf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .status     (be_status)
  );

  `PCF_ASSERT_NOW(a_closed_has_no_bytes, !fe_status.chunk_open, fe_status.bytes_zero)
  `PCF_ASSERT_NOW(a_mid_cmd_has_head, be_status.mid_cmd, be_status.head_valid)
  `PCF_ASSERT_NEXT(a_no_result_from_empty_queue, !be_status.head_valid,
                   !out_valid || $past(out_valid && out_stall))

endmodule

// ===== rtl/pcf_front.sv =====
// Front end: accepts items, tracks the open chunk and turns each item into a command.
module pcf_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  pcf_pkg::in_item_t in_data,
  output pcf_pkg::cmd_t    cmd,
  output pcf_pkg::fe_status_t status
);

  logic        chunk_open_r, chunk_open_nxt;
  logic [30:0] bytes_left_r, bytes_left_nxt;

  always_comb begin
    cmd.length     = in_data.chunk_length;
    cmd.ctype      = in_data.chunk_type;
    cmd.data       = in_data.data_byte;
    cmd.kind       = pcf_pkg::CMD_STRAY;
    cmd.err        = 1'b1;
    cmd.last       = 1'b1;
    chunk_open_nxt = chunk_open_r;
    bytes_left_nxt = bytes_left_r;
    if (in_data.op == pcf_pkg::OP_START) begin
      cmd.kind       = pcf_pkg::CMD_START;
      cmd.err        = chunk_open_r;
      cmd.last       = (in_data.chunk_length == 31'd0);
      chunk_open_nxt = (in_data.chunk_length != 31'd0);
      bytes_left_nxt = in_data.chunk_length;
    end else if (chunk_open_r) begin
      cmd.kind       = pcf_pkg::CMD_DATA;
      cmd.err        = 1'b0;
      cmd.last       = (bytes_left_r == 31'd1);
      chunk_open_nxt = (bytes_left_r != 31'd1);
      bytes_left_nxt = bytes_left_r - 31'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_open_r <= 1'b0;
      bytes_left_r <= 31'd0;
    end else if (accept) begin
      chunk_open_r <= chunk_open_nxt;
      bytes_left_r <= bytes_left_nxt;
    end
  end

  assign status.chunk_open = chunk_open_r;
  assign status.bytes_zero = (bytes_left_r == 31'd0);

endmodule

// ===== rtl/pcf_queue.sv =====
// Short command queue between the front end and the byte sequencer.
module pcf_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pcf_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output pcf_pkg::cmd_t head
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  pcf_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/pcf_back.sv =====
// Back end: steps through each command, emits framed bytes and keeps the running CRC.
module pcf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  pcf_pkg::cmd_t        head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pcf_pkg::out_item_t   out_data,
  output pcf_pkg::be_status_t  status
);

  logic [pcf_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [31:0]                crc_r, crc_nxt;
  logic                       out_valid_r;
  pcf_pkg::out_item_t         out_data_r, item;
  logic                       advance, emit, last_step;
  logic [31:0]                crc_out;

  assign advance = !out_valid_r || !out_stall;
  assign emit    = head_valid && advance;
  assign pop     = emit && last_step;
  assign crc_out = ~crc_r;

  always_comb begin
    item      = '0;
    last_step = 1'b1;
    crc_nxt   = crc_r;
    case (head.kind)
      pcf_pkg::CMD_START: begin
        item.error_flag = head.err;
        last_step       = head.last ? (step_r == pcf_pkg::STEP_HDR_END)
                                    : (step_r == pcf_pkg::STEP_TYPE_LAST);
        if (step_r <= pcf_pkg::STEP_LEN_LAST) begin
          item.out_byte = pcf_pkg::be_byte({1'b0, head.length}, step_r[1:0]);
        end else if (step_r <= pcf_pkg::STEP_TYPE_LAST) begin
          item.out_byte = pcf_pkg::be_byte(head.ctype, step_r[1:0]);
          crc_nxt = pcf_pkg::crc_byte((step_r == pcf_pkg::STEP_TYPE_0) ? pcf_pkg::CRC_INIT
                                                                      : crc_r,
                                      item.out_byte);
        end else begin
          item.out_byte     = pcf_pkg::be_byte(crc_out, step_r[1:0]);
          item.end_of_chunk = (step_r == pcf_pkg::STEP_HDR_END);
          if (item.end_of_chunk) begin
            crc_nxt = pcf_pkg::CRC_INIT;
          end
        end
      end
      pcf_pkg::CMD_DATA: begin
        last_step = head.last ? (step_r == pcf_pkg::STEP_DATA_END) : (step_r == '0);
        if (step_r == '0) begin
          item.out_byte = head.data;
          crc_nxt       = pcf_pkg::crc_byte(crc_r, head.data);
        end else begin
          item.out_byte     = pcf_pkg::be_byte(crc_out, step_r[1:0] - 2'd1);
          item.end_of_chunk = (step_r == pcf_pkg::STEP_DATA_END);
          if (item.end_of_chunk) begin
            crc_nxt = pcf_pkg::CRC_INIT;
          end
        end
      end
      default: begin
        item.error_flag = 1'b1;
      end
    endcase
    step_nxt = last_step ? '0 : step_r + pcf_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= '0;
      crc_r       <= pcf_pkg::CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        step_r <= step_nxt;
        crc_r  <= crc_nxt;
      end
      if (advance) begin
        out_valid_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= item;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data          = out_data_r;
  assign status.mid_cmd    = (step_r != '0);
  assign status.head_valid = head_valid;

endmodule

// ===== dv/tb_png_chunk_framer_crc32_unit.sv =====
// Self-checking testbench for the PNG chunk framer: directed table, random chunks, CRC predictor.
`timescale 1ns / 1ps

module tb_png_chunk_framer_crc32_unit;

  localparam int DIRECTED_ROWS = 18;
  localparam int RANDOM_ITEMS  = 462;
  localparam int CALM_ITEMS    = 60;
  localparam int SETTLE_CYCLES = 32;

  typedef struct {
    pcf_pkg::in_item_t  item;
    logic               has_typed;
    pcf_pkg::out_item_t typed_res;
  } dir_row_t;

  logic               clk;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  pcf_pkg::in_item_t  in_data   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pcf_pkg::out_item_t out_data;

  pcf_pkg::out_item_t expected_bytes[$];
  logic [31:0] crc_reg       = pcf_pkg::CRC_INIT;
  logic [30:0] bytes_pending = '0;
  logic        chunk_live    = 1'b0;
  int          error_count   = 0;
  int          sent_count    = 0;
  int unsigned rx_hold       = 0;
  logic        idling_on     = 1'b1;

  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{pcf_pkg::OP_DATA,  31'd0,         32'h0000_0000, 8'hFF}, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{'{pcf_pkg::OP_DATA,  31'h7FFF_FFFF, 32'hFFFF_FFFF, 8'h00}, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{'{pcf_pkg::OP_START, 31'd0,         32'h4945_4E44, 8'h00}, 1'b0, '0},
    '{'{pcf_pkg::OP_START, 31'd3,         32'h4944_4154, 8'hFF}, 1'b0, '0},
    '{'{pcf_pkg::OP_DATA,  31'd0,         32'h0000_0000, 8'h00}, 1'b0, '0},
    '{'{pcf_pkg::OP_DATA,  31'd0,         32'h0000_0000, 8'hFF}, 1'b0, '0},
    '{'{pcf_pkg::OP_DATA,  31'd0,         32'h0000_0000, 8'hA5}, 1'b0, '0},
    '{'{pcf_pkg::OP_DATA,  31'd5,         32'h1234_5678, 8'h01}, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{'{pcf_pkg::OP_START, 31'd2,         32'h7445_5874, 8'h00}, 1'b0, '0},
    '{'{pcf_pkg::OP_DATA,  31'd0,         32'h0000_0000, 8'h5A}, 1'b0, '0},
    '{'{pcf_pkg::OP_START, 31'd1,         32'hFFFF_FFFF, 8'h00}, 1'b0, '0},
    '{'{pcf_pkg::OP_DATA,  31'd0,         32'h0000_0000, 8'h80}, 1'b0, '0},
    '{'{pcf_pkg::OP_START, 31'h7FFF_FFFF, 32'h0000_0000, 8'hFF}, 1'b0, '0},
    '{'{pcf_pkg::OP_DATA,  31'd0,         32'h0000_0000, 8'h3C}, 1'b0, '0},
    '{'{pcf_pkg::OP_START, 31'd0,         32'hFFFF_FFFF, 8'h00}, 1'b0, '0},
    '{'{pcf_pkg::OP_DATA,  31'd0,         32'h0000_0000, 8'hC3}, 1'b1, '{8'h00, 1'b0, 1'b1}},
    '{'{pcf_pkg::OP_START, 31'd1,         32'h4948_4452, 8'h00}, 1'b0, '0},
    '{'{pcf_pkg::OP_DATA,  31'd0,         32'h0000_0000, 8'h7E}, 1'b0, '0}
  };

  png_chunk_framer_crc32_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  function automatic logic [31:0] crc32_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = {1'b0, c[31:1]} ^ (fb ? pcf_pkg::CRC_POLY : 32'd0);
    end
    return c;
  endfunction

  function automatic void append_crc(inout pcf_pkg::out_item_t res[$], input logic err);
    logic [31:0] v;
    v = ~crc_reg;
    for (int i = 3; i >= 0; i--) begin
      res.push_back('{v[8*i +: 8], (i == 0), err});
    end
    crc_reg       = pcf_pkg::CRC_INIT;
    bytes_pending = '0;
    chunk_live    = 1'b0;
  endfunction

  function automatic void frame_item(input pcf_pkg::in_item_t it,
                                     output pcf_pkg::out_item_t res[$]);
    logic [31:0] len32;
    logic [7:0]  b;
    logic        err;
    res = {};
    if (it.op == pcf_pkg::OP_START) begin
      err   = chunk_live;
      len32 = {1'b0, it.chunk_length};
      for (int i = 3; i >= 0; i--) begin
        res.push_back('{len32[8*i +: 8], 1'b0, err});
      end
      crc_reg = pcf_pkg::CRC_INIT;
      for (int i = 3; i >= 0; i--) begin
        b = it.chunk_type[8*i +: 8];
        res.push_back('{b, 1'b0, err});
        crc_reg = crc32_fold(crc_reg, b);
      end
      bytes_pending = it.chunk_length;
      chunk_live    = 1'b1;
      if (it.chunk_length == 31'd0) begin
        append_crc(res, err);
      end
    end else if (!chunk_live) begin
      res.push_back('{8'h00, 1'b0, 1'b1});
    end else begin
      res.push_back('{it.data_byte, 1'b0, 1'b0});
      crc_reg       = crc32_fold(crc_reg, it.data_byte);
      bytes_pending = bytes_pending - 31'd1;
      if (bytes_pending == 31'd0) begin
        append_crc(res, 1'b0);
      end
    end
  endfunction

  function automatic pcf_pkg::in_item_t make_start(input logic [30:0] len);
    pcf_pkg::in_item_t it;
    it.op           = pcf_pkg::OP_START;
    it.chunk_length = len;
    it.chunk_type   = $urandom;
    it.data_byte    = 8'($urandom);
    return it;
  endfunction

  function automatic pcf_pkg::in_item_t make_data();
    pcf_pkg::in_item_t it;
    it.op           = pcf_pkg::OP_DATA;
    it.chunk_length = 31'($urandom);
    it.chunk_type   = $urandom;
    it.data_byte    = 8'($urandom);
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("mismatch at %0t: %s, got %02h, expected %02h", $time, what, got, want);
    error_count++;
  endtask

  task automatic send_item(input pcf_pkg::in_item_t it, input logic has_typed,
                           input pcf_pkg::out_item_t typed_res);
    pcf_pkg::out_item_t predicted[$];
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_item(it, predicted);
    if (has_typed) begin
      expected_bytes.push_back(typed_res);
    end else begin
      foreach (predicted[i]) expected_bytes.push_back(predicted[i]);
    end
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold   <= rx_hold - 1;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      rx_hold   <= $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    pcf_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("transaction with nothing expected", out_data.out_byte, 8'h00);
      end else begin
        want = expected_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_data.out_byte, want.out_byte);
        if (out_data.end_of_chunk !== want.end_of_chunk)
          report_mismatch("end_of_chunk", 8'(out_data.end_of_chunk),
                          8'(want.end_of_chunk));
        if (out_data.error_flag !== want.error_flag)
          report_mismatch("error_flag", 8'(out_data.error_flag), 8'(want.error_flag));
      end
    end
  end

  initial begin
    logic [30:0] len;
    int          pick;
    int          total;
    logic        drained_mid;
    total       = DIRECTED_ROWS + RANDOM_ITEMS;
    drained_mid = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      send_item(directed_rows[r].item, directed_rows[r].has_typed, directed_rows[r].typed_res);
    end
    wait_drained();

    while (sent_count < total) begin
      idling_on = (sent_count < total - CALM_ITEMS) && ($urandom_range(0, 4) != 0);
      if (!drained_mid && sent_count >= DIRECTED_ROWS + RANDOM_ITEMS / 2) begin
        wait_drained();
        drained_mid = 1'b1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        len = ($urandom_range(0, 15) == 0) ? 31'($urandom_range(13, 40))
                                           : 31'($urandom_range(0, 12));
        send_item(make_start(len), 1'b0, '0);
        repeat (len) send_item(make_data(), 1'b0, '0);
      end else if (pick == 7) begin
        repeat ($urandom_range(1, 3)) send_item(make_data(), 1'b0, '0);
      end else if (pick == 8) begin
        len = 31'($urandom);
        send_item(make_start(len), 1'b0, '0);
        repeat ($urandom_range(0, 6)) send_item(make_data(), 1'b0, '0);
      end else begin
        len = 31'($urandom_range(2, 12));
        send_item(make_start(len), 1'b0, '0);
        repeat ($urandom_range(0, len - 1)) send_item(make_data(), 1'b0, '0);
      end
    end

    idling_on = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
